[sv/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes shared by the postfix stack evaluator modules.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DataW = 32;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_OP   = 2'd1,
    MODE_END  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_BAD_OP   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_DIV_ZERO = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [1:0] {
    EX_IDLE = 2'd0,
    EX_MUL  = 2'd1,
    EX_DIV  = 2'd2,
    EX_OUT  = 2'd3
  } ex_state_t;

endpackage

[sv/pse_if.sv]
// ----------------------------------------------------------------------------
// pse token and result channels
// Valid/ready channels carrying one input token or one result word.
// ----------------------------------------------------------------------------
interface pse_tok_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [31:0] number_value;
  logic [7:0]        operator_char;
  modport source (output valid, mode, number_value, operator_char, input ready);
  modport sink   (input valid, mode, number_value, operator_char, output ready);
endinterface

interface pse_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] result_value;
  logic              expression_done;
  modport source (output valid, status, result_value, expression_done, input ready);
  modport sink   (input valid, status, result_value, expression_done, output ready);
endinterface

[sv/postfix_stack_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix token evaluator on a bounded Q16.16 operand stack.
// ----------------------------------------------------------------------------
// Each accepted token gives one result word. Push, end, no-op and error tokens
// leave the back end free once their result can be taken; add and subtract
// hold it while the new second entry, if needed, is refilled from the RAM;
// multiply holds it through EX_MUL and EX_OUT, since the 32x32 product is
// registered before it is scaled and saturated; divide holds it through the
// 48 one-bit steps of the divider and the hand-over of the quotient. A
// two-entry queue in front keeps taking tokens while the back end works. The
// top two entries sit in registers, the rest in a RAM with a registered read.
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pse_tok_if.sink    in_tok,
  pse_res_if.source  out_res
);
  import pse_pkg::*;

  logic             cmd_valid, cmd_ready, cmd_bad_op;
  mode_t            cmd_mode;
  alu_op_t          cmd_op;
  logic signed [31:0] cmd_num;

  pse_front u_front (
    .clk, .rst_n, .tok(in_tok), .cmd_valid, .cmd_ready,
    .cmd_mode, .cmd_op, .cmd_bad_op, .cmd_num
  );

  pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_mode, .cmd_op,
    .cmd_bad_op, .cmd_num, .res(out_res)
  );
endmodule

[sv/pse_ram.sv]
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write RAM with one registered read port.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/pse_front.sv]
// ----------------------------------------------------------------------------
// pse_front
// Accepts tokens and decodes them into a compact command word.
// ----------------------------------------------------------------------------
module pse_front (
  input  logic                 clk,
  input  logic                 rst_n,
  pse_tok_if.sink              tok,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output pse_pkg::mode_t       cmd_mode,
  output pse_pkg::alu_op_t     cmd_op,
  output logic                 cmd_bad_op,
  output logic signed [31:0]   cmd_num
);
  import pse_pkg::*;

  mode_t          q_mode_r  [2];
  alu_op_t        q_op_r    [2];
  logic           q_bad_r   [2];
  logic [31:0]    q_num_r   [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  alu_op_t        dec_op;
  logic           dec_bad;
  logic           push, pop;

  // Operator byte decode.
  always_comb begin
    dec_bad = 1'b0;
    case (tok.operator_char)
      ChPlus:  dec_op = OP_ADD;
      ChMinus: dec_op = OP_SUB;
      ChMul:   dec_op = OP_MUL;
      ChDiv:   dec_op = OP_DIV;
      default: begin
        dec_op  = OP_ADD;
        dec_bad = 1'b1;
      end
    endcase
  end

  assign tok.ready = (cnt_r != 2'd2);
  assign push      = tok.valid && tok.ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_mode  = q_mode_r[rp_r];
  assign cmd_op    = q_op_r[rp_r];
  assign cmd_bad_op = q_bad_r[rp_r];
  assign cmd_num   = q_num_r[rp_r];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mode_r[wp_r]  <= mode_t'(tok.mode);
      q_op_r[wp_r]    <= dec_op;
      q_bad_r[wp_r]   <= dec_bad;
      q_num_r[wp_r]   <= tok.number_value;
    end
  end
endmodule

[sv/pse_div.sv]
// ----------------------------------------------------------------------------
// pse_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW:0]   rem_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem_r[DW-1:0], q_r[NW-1]};
  assign ge      = shifted >= {1'b0, d_r};
  assign quo     = q_r;
  assign done    = busy_r && (cnt_r == CW'(0));

  // Iteration: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      rem_r  <= '0;
      q_r    <= num;
      d_r    <= den;
    end else if (busy_r) begin
      if (cnt_r == CW'(0)) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CW'(1);
        rem_r <= ge ? (shifted - {1'b0, d_r}) : shifted;
        q_r   <= {q_r[NW-2:0], ge};
      end
    end
  end
endmodule

[sv/pse_back.sv]
// ----------------------------------------------------------------------------
// pse_back
// Executes commands against the operand stack and produces results.
// ----------------------------------------------------------------------------
module pse_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  pse_pkg::mode_t       cmd_mode,
  input  pse_pkg::alu_op_t     cmd_op,
  input  logic                 cmd_bad_op,
  input  logic signed [31:0]   cmd_num,
  pse_res_if.source            res
);
  import pse_pkg::*;

  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [31:0] MaxV = 32'h7FFF_FFFF;
  localparam logic [31:0] MinV = 32'h8000_0000;

  // Top two entries are kept in registers; deeper entries live in RAM.
  logic [31:0]   top_r, nos_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ex_state_t     st_r, st_nxt;
  alu_op_t       op_r;
  logic [31:0]   a_r, b_r;
  logic          neg_r;
  logic [63:0]   prod_r;
  logic          o_valid_r;
  logic [2:0]    o_status_r;
  logic [31:0]   o_value_r;
  logic          o_done_r;
  logic          refill_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic          take;
  logic          out_free;
  logic [31:0]   ma, mb;
  logic [32:0]   sum;
  logic [31:0]   addv;
  logic [47:0]   div_num;
  logic          div_start, div_done;
  logic [47:0]   div_quo;
  logic [31:0]   mul_res, div_res;

  pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign out_free  = !o_valid_r || res.ready;
  assign cmd_ready = (st_r == EX_IDLE) && out_free && !refill_r;
  assign take      = cmd_valid && cmd_ready;

  function automatic logic [31:0] sat_mag(input logic [47:0] m, input logic neg);
    logic [47:0] lim;
    logic [31:0] r;
    begin
      lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
      r   = (m > lim) ? lim[31:0] : m[31:0];
      sat_mag = neg ? (32'd0 - r) : r;
    end
  endfunction

  assign ma = nos_r[31] ? (32'd0 - nos_r) : nos_r;
  assign mb = top_r[31] ? (32'd0 - top_r) : top_r;
  assign sum = (cmd_op == OP_SUB) ? ({nos_r[31], nos_r} - {top_r[31], top_r})
                                  : ({nos_r[31], nos_r} + {top_r[31], top_r});
  assign addv = (sum[32] != sum[31]) ? (sum[32] ? MinV : MaxV) : sum[31:0];
  assign div_num = {ma, 16'd0};
  assign div_start = take && cmd_mode == MODE_OP && cnt_r >= CW'(2) && !cmd_bad_op
                     && cmd_op == OP_DIV && top_r != 32'd0;
  assign mul_res = sat_mag((prod_r[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : prod_r[63:16],
                           neg_r);
  assign div_res = sat_mag(div_quo, neg_r);

  // The divider latches its operands at start, so it takes the live divisor.
  pse_div #(.NW(48), .DW(32)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(mb),
    .done(div_done), .quo(div_quo)
  );

  // RAM port: spill nos on push, read new nos after a pop.
  always_comb begin
    ram_we    = take && cmd_mode == MODE_PUSH && cnt_r >= CW'(2)
                && cnt_r < CW'(STACK_DEPTH);
    ram_waddr = AW'(cnt_r - CW'(2));
    ram_wdata = nos_r;
    ram_raddr = AW'(cnt_r - CW'(3));
  end

  // Next state of the execute sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_IDLE: if (take && cmd_mode == MODE_OP && cnt_r >= CW'(2) && !cmd_bad_op) begin
        if (cmd_op == OP_MUL) st_nxt = EX_MUL;
        else if (div_start)   st_nxt = EX_DIV;
      end
      EX_MUL:  st_nxt = EX_OUT;
      EX_DIV:  if (div_done) st_nxt = EX_OUT;
      EX_OUT:  if (out_free) st_nxt = EX_IDLE;
      default: st_nxt = EX_IDLE;
    endcase
  end

  // Stack count update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      case (cmd_mode)
        MODE_PUSH: cnt_nxt = (cnt_r >= CW'(STACK_DEPTH)) ? '0 : cnt_r + CW'(1);
        MODE_OP: begin
          if (cnt_r < CW'(2) || cmd_bad_op) cnt_nxt = '0;
          else if (cmd_op == OP_DIV && top_r == 32'd0) cnt_nxt = '0;
          else cnt_nxt = cnt_r - CW'(1);
        end
        MODE_END: cnt_nxt = '0;
        default:  cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= EX_IDLE;
      cnt_r     <= '0;
      o_valid_r <= 1'b0;
      refill_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      refill_r <= take && cmd_mode == MODE_OP && cnt_nxt >= CW'(2)
                  && cnt_nxt < cnt_r;
      if (res.valid && res.ready) o_valid_r <= 1'b0;
      if (take || (st_r == EX_OUT && out_free)) o_valid_r <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (refill_r) nos_r <= ram_rdata;
    if (take) begin
      o_status_r <= ST_OK;
      o_value_r  <= '0;
      o_done_r   <= 1'b0;
      op_r       <= cmd_op;
      a_r        <= ma;
      b_r        <= mb;
      neg_r      <= nos_r[31] ^ top_r[31];
      case (cmd_mode)
        MODE_PUSH: begin
          if (cnt_r >= CW'(STACK_DEPTH)) o_status_r <= ST_OVERFLOW;
          else begin
            nos_r <= top_r;
            top_r <= cmd_num;
          end
        end
        MODE_OP: begin
          if (cnt_r < CW'(2)) o_status_r <= ST_FEW;
          else if (cmd_bad_op) o_status_r <= ST_BAD_OP;
          else if (cmd_op == OP_DIV && top_r == 32'd0) begin
            o_status_r <= ST_DIV_ZERO;
            o_value_r  <= nos_r[31] ? MinV : MaxV;
          end else if (cmd_op == OP_ADD || cmd_op == OP_SUB) top_r <= addv;
        end
        MODE_END: begin
          if (cnt_r == '0) o_status_r <= ST_EMPTY;
          else begin
            o_value_r <= top_r;
            o_done_r  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (st_r == EX_MUL) prod_r <= {32'd0, a_r} * {32'd0, b_r};
    if (st_r == EX_OUT && out_free) top_r <= (op_r == OP_MUL) ? mul_res : div_res;
  end

  assign res.valid           = o_valid_r && st_r != EX_MUL && st_r != EX_DIV
                               && st_r != EX_OUT;
  assign res.status          = o_status_r;
  assign res.result_value    = o_value_r;
  assign res.expression_done = o_done_r;
endmodule

[sv/pse_checker.sv]
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks on the result channel of the evaluator.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_result_value,
  input logic        out_expression_done
);
  import pse_pkg::*;

  // A closed expression always reports ok status.
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expression_done |-> out_status == ST_OK)
    else $error("done with error status");

  // Status codes above empty-at-end never appear.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EMPTY)
    else $error("bad status code");

  // A stalled result holds its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");

  // A stalled result holds its value and done flag.
  a_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_value) && $stable(out_expression_done))
    else $error("result changed while stalled");
endmodule

bind postfix_stack_evaluator_unit pse_checker u_chk (
  .clk, .rst_n, .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_status(out_res.status), .out_result_value(out_res.result_value),
  .out_expression_done(out_res.expression_done)
);
